### rtl/core/windowed_detection_smoother_assert.svh
// Assertion macros for the windowed detection smoother.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef WINDOWED_DETECTION_SMOOTHER_ASSERT_SVH
`define WINDOWED_DETECTION_SMOOTHER_ASSERT_SVH
`ifndef SYNTHESIS
`define WDS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("windowed_detection_smoother: same-cycle check failed");
`define WDS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("windowed_detection_smoother: next-cycle check failed");
`else
`define WDS_ASSERT_IMP(label, ante, cons)
`define WDS_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/core/wds_pkg.sv
// Shared types and codes of the windowed detection smoother.
// No dependencies.
`timescale 1ns / 1ps
package wds_pkg;

    localparam logic [1:0] OP_VIEW = 2'd0;
    localparam logic [1:0] OP_DET  = 2'd1;
    localparam logic [1:0] OP_EOF  = 2'd2;
    localparam logic [1:0] OP_CLR  = 2'd3;

    localparam logic [1:0] KIND_VIEW = 2'd0;
    localparam logic [1:0] KIND_DET  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [1:0] CFG_WINDOW = 2'd0;
    localparam logic [1:0] CFG_THRESH = 2'd1;
    localparam logic [1:0] CFG_FRAC   = 2'd2;
    localparam logic [1:0] CFG_MASK   = 2'd3;

    localparam logic [4:0]  RST_WINDOW = 5'd16;
    localparam logic [15:0] RST_THRESH = 16'd26214;
    localparam logic [15:0] RST_FRAC   = 16'd26214;

    localparam logic [2:0] LAST_FIELD = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  in_index;
        logic [15:0] in_score;
        logic [15:0] in_x;
        logic [15:0] in_y;
        logic [15:0] in_w;
        logic [15:0] in_h;
        logic [15:0] in_conf;
    } t_in;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [2:0]  view_class;
        logic [15:0] view_prob;
        logic [2:0]  out_label;
        logic [15:0] avg_x;
        logic [15:0] avg_y;
        logic [15:0] avg_w;
        logic [15:0] avg_h;
        logic [15:0] avg_conf;
        logic        last_result;
    } t_out;

    typedef struct packed {
        logic       accept;
        logic       view_wr;
        logic       box_wr;
        logic       rd;
        logic       vacc;
        logic       bacc;
        logic       acc_clr;
        logic       div_start;
        logic       div_view;
        logic       best_upd;
        logic       det_ld;
        logic       drop;
        logic       need_ld;
        logic       pend_view;
        logic       push_det;
        logic       push_fin;
        logic       err_out;
        logic [2:0] idx;
        logic [2:0] k;
    } t_cmd;

    typedef struct packed {
        logic eof;
        logic count_ok;
        logic out_free;
        logic div_done;
        logic mask_bit;
        logic cnt_gt_need;
    } t_stat;

endpackage

### rtl/core/wds_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module wds_div #(
    parameter int DW = 23,
    parameter int SW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [SW-1:0] i_divisor,
    output logic [DW-1:0] o_quot,
    output logic          o_done
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [SW-1:0] r_rem, r_d, n_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done, n_bit;
    logic [SW:0]   rem_sh;

    always_comb begin
        rem_sh = {r_rem, r_q[DW-1]};
        if (rem_sh >= {1'b0, r_d}) begin
            n_rem = SW'(rem_sh - {1'b0, r_d});
            n_bit = 1'b1;
        end else begin
            n_rem = rem_sh[SW-1:0];
            n_bit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], n_bit};
            r_rem <= n_rem;
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;
endmodule

### rtl/core/wds_ctrl.sv
// Sequencer of the windowed detection smoother: walks the frame ring at end of frame.
// Depends on wds_pkg.
`timescale 1ns / 1ps
module wds_ctrl #(
    parameter int WINDOW_DEPTH  = 16,
    parameter int VIEW_CLASSES  = 8,
    parameter int LABEL_CLASSES = 8,
    parameter int SLOT_W        = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  wds_pkg::t_stat    i_stat,
    input  logic [SLOT_W-1:0] i_len_last,
    output logic              o_in_ready,
    output wds_pkg::t_cmd     o_cmd,
    output logic [SLOT_W-1:0] o_row
);
    localparam logic [2:0] VIEW_LAST  = 3'(VIEW_CLASSES - 1);
    localparam logic [2:0] LABEL_LAST = 3'(LABEL_CLASSES - 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_VWR   = 5'd2;
    localparam logic [4:0] S_VRD   = 5'd3;
    localparam logic [4:0] S_VACC  = 5'd4;
    localparam logic [4:0] S_VDST  = 5'd5;
    localparam logic [4:0] S_VDW   = 5'd6;
    localparam logic [4:0] S_BWR   = 5'd7;
    localparam logic [4:0] S_VOUT  = 5'd8;
    localparam logic [4:0] S_LAB   = 5'd9;
    localparam logic [4:0] S_BRD   = 5'd10;
    localparam logic [4:0] S_BACC  = 5'd11;
    localparam logic [4:0] S_BCHK  = 5'd12;
    localparam logic [4:0] S_BDST  = 5'd13;
    localparam logic [4:0] S_BDW   = 5'd14;
    localparam logic [4:0] S_BPUSH = 5'd15;
    localparam logic [4:0] S_FIN   = 5'd16;

    logic [4:0]        r_state, n_state;
    logic [2:0]        r_idx, n_idx, r_k, n_k;
    logic [SLOT_W-1:0] r_row, n_row;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_k        = r_k;
        n_row      = r_row;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_cmd.k    = r_k;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_stat.eof) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_stat.count_ok) begin
                    if (i_stat.out_free) begin
                        o_cmd.err_out = 1'b1;
                        o_cmd.drop    = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    n_idx   = '0;
                    n_state = S_VWR;
                end
            end
            S_VWR: begin
                o_cmd.view_wr = 1'b1;
                if (r_idx == VIEW_LAST) begin
                    n_idx         = '0;
                    n_row         = '0;
                    o_cmd.acc_clr = 1'b1;
                    n_state       = S_VRD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_VRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_VACC;
            end
            S_VACC: begin
                o_cmd.vacc = 1'b1;
                if (r_row == i_len_last) begin
                    n_state = S_VDST;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_VRD;
                end
            end
            S_VDST: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_view  = 1'b1;
                n_state         = S_VDW;
            end
            S_VDW: begin
                if (i_stat.div_done) begin
                    o_cmd.best_upd = 1'b1;
                    if (r_idx == VIEW_LAST) begin
                        n_idx   = '0;
                        n_state = S_BWR;
                    end else begin
                        n_idx         = r_idx + 1'b1;
                        n_row         = '0;
                        o_cmd.acc_clr = 1'b1;
                        n_state       = S_VRD;
                    end
                end
            end
            S_BWR: begin
                o_cmd.box_wr = 1'b1;
                if (r_idx == LABEL_LAST) begin
                    o_cmd.drop    = 1'b1;
                    o_cmd.need_ld = 1'b1;
                    n_state       = S_VOUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_VOUT: begin
                o_cmd.pend_view = 1'b1;
                n_idx           = '0;
                n_state         = S_LAB;
            end
            S_LAB: begin
                if (i_stat.mask_bit) begin
                    o_cmd.acc_clr = 1'b1;
                    n_row         = '0;
                    n_state       = S_BRD;
                end else if (r_idx == LABEL_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_BRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_BACC;
            end
            S_BACC: begin
                o_cmd.bacc = 1'b1;
                if (r_row == i_len_last) begin
                    n_state = S_BCHK;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_BRD;
                end
            end
            S_BCHK: begin
                if (i_stat.cnt_gt_need) begin
                    n_k     = '0;
                    n_state = S_BDST;
                end else if (r_idx == LABEL_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_LAB;
                end
            end
            S_BDST: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_BDW;
            end
            S_BDW: begin
                if (i_stat.div_done) begin
                    o_cmd.det_ld = 1'b1;
                    if (r_k == wds_pkg::LAST_FIELD) begin
                        n_state = S_BPUSH;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_BDST;
                    end
                end
            end
            S_BPUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push_det = 1'b1;
                    if (r_idx == LABEL_LAST) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_LAB;
                    end
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.push_fin = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_k     <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_k     <= n_k;
            r_row   <= n_row;
        end
    end

    assign o_row = r_row;
endmodule

### rtl/core/wds_dp.sv
// Datapath of the windowed detection smoother: config, staging, ring memories,
// accumulators, divider and result registers. Depends on wds_pkg and wds_div.
`timescale 1ns / 1ps
module wds_dp #(
    parameter int WINDOW_DEPTH  = 16,
    parameter int VIEW_CLASSES  = 8,
    parameter int LABEL_CLASSES = 8,
    parameter int SLOT_W        = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  wds_pkg::t_in      i_in_data,
    input  wds_pkg::t_cmd     i_cmd,
    input  logic [SLOT_W-1:0] i_row,
    input  logic              i_out_ready,
    output wds_pkg::t_stat    o_stat,
    output logic [SLOT_W-1:0] o_len_last,
    output logic              o_out_valid,
    output wds_pkg::t_out     o_out_data
);
    localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = 16 + LEN_W;
    localparam int ADDR_W = SLOT_W + 3;
    localparam int MEM_D  = WINDOW_DEPTH * 8;

    logic [4:0]  r_wl;
    logic [15:0] r_thr, r_frac;
    logic [63:0] r_mask;

    logic [15:0] r_sview [8];
    logic [63:0] r_sbox  [8];
    logic [15:0] r_sconf [8];
    logic [3:0]  r_vcount;

    logic [SLOT_W-1:0] r_wslot, r_slot, slot, nxt_slot;
    logic [LEN_W-1:0]  len, r_need, r_cnt;
    logic [LEN_W+15:0] need_prod;

    logic [15:0] view_mem [MEM_D];
    logic [63:0] box_mem  [MEM_D];
    logic [15:0] conf_mem [MEM_D];
    logic [WINDOW_DEPTH-1:0] r_vvld, r_bvld;
    logic [15:0] r_vrd, r_crd, vdata, cdata;
    logic [63:0] r_brd, bdata;
    logic        r_rd_vv, r_rd_bv;
    logic [ADDR_W-1:0] waddr, raddr;

    logic [SUM_W-1:0] r_sum [5];
    logic [15:0]      r_det [5];
    logic [2:0]       r_best;
    logic [15:0]      r_bestv;

    logic [SUM_W-1:0] div_q;
    logic             div_done;

    wds_pkg::t_out r_out, r_pend, det_res, view_res, err_res, fin_res;
    logic          r_out_vld, out_free, out_load;
    logic          acc_in;

    // effective window length, out-of-range settings clamped
    always_comb begin
        if (r_wl == 5'd0) begin
            len = LEN_W'(1);
        end else if (32'(r_wl) > WINDOW_DEPTH) begin
            len = LEN_W'(WINDOW_DEPTH);
        end else begin
            len = LEN_W'(r_wl);
        end
        slot     = (8'(r_wslot) < 8'(len)) ? r_wslot : '0;
        nxt_slot = (8'(slot) + 8'd1 >= 8'(len)) ? '0 : SLOT_W'(slot + 1'b1);
        need_prod = (LEN_W + 16)'(len) * (LEN_W + 16)'(r_frac);
    end

    assign o_len_last = SLOT_W'(len - 1'b1);
    assign acc_in     = i_cmd.accept;
    assign waddr      = {r_slot, i_cmd.idx};
    assign raddr      = {i_row, i_cmd.idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl   <= wds_pkg::RST_WINDOW;
            r_thr  <= wds_pkg::RST_THRESH;
            r_frac <= wds_pkg::RST_FRAC;
            r_mask <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wds_pkg::CFG_WINDOW: r_wl   <= i_cfg_data[4:0];
                wds_pkg::CFG_THRESH: r_thr  <= i_cfg_data[15:0];
                wds_pkg::CFG_FRAC:   r_frac <= i_cfg_data[15:0];
                wds_pkg::CFG_MASK:   r_mask <= i_cfg_data;
            endcase
        end
    end

    // staged view scores persist across frames and need no reset
    always_ff @(posedge i_clk) begin
        if (acc_in && i_in_data.operation == wds_pkg::OP_VIEW &&
            32'(i_in_data.in_index) < VIEW_CLASSES) begin
            r_sview[i_in_data.in_index] <= i_in_data.in_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            r_wslot  <= '0;
            r_vvld   <= '0;
            r_bvld   <= '0;
            for (int i = 0; i < 8; i++) begin
                r_sbox[i]  <= '0;
                r_sconf[i] <= '0;
            end
        end else begin
            if (acc_in) begin
                unique case (i_in_data.operation)
                    wds_pkg::OP_VIEW: begin
                        if (r_vcount != 4'd15) r_vcount <= r_vcount + 1'b1;
                    end
                    wds_pkg::OP_DET: begin
                        if (32'(i_in_data.in_index) < LABEL_CLASSES) begin
                            r_sbox[i_in_data.in_index] <= {i_in_data.in_h, i_in_data.in_w,
                                                           i_in_data.in_y, i_in_data.in_x};
                            r_sconf[i_in_data.in_index] <= i_in_data.in_conf;
                        end
                    end
                    wds_pkg::OP_EOF: r_wslot <= nxt_slot;
                    wds_pkg::OP_CLR: begin
                        r_wslot  <= '0;
                        r_vvld   <= '0;
                        r_bvld   <= '0;
                        r_vcount <= '0;
                        for (int i = 0; i < 8; i++) begin
                            r_sbox[i]  <= '0;
                            r_sconf[i] <= '0;
                        end
                    end
                endcase
            end
            if (i_cmd.view_wr) r_vvld[r_slot] <= 1'b1;
            if (i_cmd.box_wr)  r_bvld[r_slot] <= 1'b1;
            if (i_cmd.drop) begin
                r_vcount <= '0;
                for (int i = 0; i < 8; i++) begin
                    r_sbox[i]  <= '0;
                    r_sconf[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in && i_in_data.operation == wds_pkg::OP_EOF) r_slot <= slot;
    end

    // ring memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.view_wr) view_mem[waddr] <= r_sview[i_cmd.idx];
        if (i_cmd.rd) begin
            r_vrd   <= view_mem[raddr];
            r_rd_vv <= r_vvld[i_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.box_wr) begin
            box_mem[waddr]  <= (r_bestv > r_thr) ? r_sbox[i_cmd.idx] : 64'd0;
            conf_mem[waddr] <= (r_bestv > r_thr) ? r_sconf[i_cmd.idx] : 16'd0;
        end
        if (i_cmd.rd) begin
            r_brd   <= box_mem[raddr];
            r_crd   <= conf_mem[raddr];
            r_rd_bv <= r_bvld[i_row];
        end
    end

    assign vdata = r_rd_vv ? r_vrd : 16'd0;
    assign bdata = r_rd_bv ? r_brd : 64'd0;
    assign cdata = r_rd_bv ? r_crd : 16'd0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            for (int i = 0; i < 5; i++) r_sum[i] <= '0;
            r_cnt <= '0;
        end else if (i_cmd.vacc) begin
            r_sum[0] <= r_sum[0] + SUM_W'(vdata);
        end else if (i_cmd.bacc && cdata != 16'd0) begin
            r_sum[0] <= r_sum[0] + SUM_W'(bdata[15:0]);
            r_sum[1] <= r_sum[1] + SUM_W'(bdata[31:16]);
            r_sum[2] <= r_sum[2] + SUM_W'(bdata[47:32]);
            r_sum[3] <= r_sum[3] + SUM_W'(bdata[63:48]);
            r_sum[4] <= r_sum[4] + SUM_W'(cdata);
            r_cnt    <= r_cnt + 1'b1;
        end
        if (i_cmd.need_ld) r_need <= need_prod[LEN_W+15:16];
        if (i_cmd.best_upd && (i_cmd.idx == 3'd0 || div_q[15:0] > r_bestv)) begin
            r_best  <= i_cmd.idx;
            r_bestv <= div_q[15:0];
        end
        if (i_cmd.det_ld) r_det[i_cmd.k] <= div_q[15:0];
    end

    wds_div #(
        .DW (SUM_W),
        .SW (LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_cmd.div_view ? r_sum[0] : r_sum[i_cmd.k]),
        .i_divisor  (i_cmd.div_view ? len : r_cnt),
        .o_quot     (div_q),
        .o_done     (div_done)
    );

    always_comb begin
        det_res             = '0;
        det_res.out_kind    = wds_pkg::KIND_DET;
        det_res.view_class  = r_best;
        det_res.view_prob   = r_bestv;
        det_res.out_label   = i_cmd.idx;
        det_res.avg_x       = r_det[0];
        det_res.avg_y       = r_det[1];
        det_res.avg_w       = r_det[2];
        det_res.avg_h       = r_det[3];
        det_res.avg_conf    = r_det[4];
        view_res            = '0;
        view_res.out_kind   = wds_pkg::KIND_VIEW;
        view_res.view_class = r_best;
        view_res.view_prob  = r_bestv;
        err_res             = '0;
        err_res.out_kind    = wds_pkg::KIND_ERR;
        err_res.last_result = 1'b1;
        fin_res             = r_pend;
        fin_res.last_result = 1'b1;
    end

    assign out_free = !r_out_vld || i_out_ready;
    assign out_load = i_cmd.push_det || i_cmd.push_fin || i_cmd.err_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pend_view) begin
            r_pend <= view_res;
        end else if (i_cmd.push_det) begin
            r_pend <= det_res;
        end
        if (i_cmd.push_det) begin
            r_out <= r_pend;
        end else if (i_cmd.push_fin) begin
            r_out <= fin_res;
        end else if (i_cmd.err_out) begin
            r_out <= err_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_comb begin
        o_stat             = '0;
        o_stat.eof         = (i_in_data.operation == wds_pkg::OP_EOF);
        o_stat.count_ok    = (r_vcount == 4'(VIEW_CLASSES));
        o_stat.out_free    = out_free;
        o_stat.div_done    = div_done;
        o_stat.mask_bit    = r_mask[{r_best, i_cmd.idx}];
        o_stat.cnt_gt_need = (r_cnt > r_need);
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
endmodule

### rtl/core/windowed_detection_smoother.sv
// Top level of the windowed detection smoother.
// Joins wds_ctrl and wds_dp; uses wds_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "windowed_detection_smoother_assert.svh"
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one item a beat:
//   view scores, detection boxes, end of frame, or clear. Score, box and clear
//   beats produce nothing.
//   An end-of-frame beat starts the sequencer; o_in_ready stays low until every
//   result of that frame has been loaded into the output register.
//   Output channel (o_out_valid / i_out_ready / o_out_data) carries one result a
//   beat; last_result marks the final beat of a frame.
//   End-of-frame time is set by the shared bit-serial divider, SUM_W bits wide,
//   and by the single read port of the ring memories.
//   Reset: all control state clears at once; the ring rows carry per-row valid
//   flags, so neither reset nor a clear beat needs a clearing pass.
//   Receiver stall: the output register holds its beat and the sequencer waits.
//   Configuration writes (i_cfg_we) take effect on the next edge; write only idle.
//
module windowed_detection_smoother #(
    parameter int WINDOW_DEPTH  = 16,
    parameter int VIEW_CLASSES  = 8,
    parameter int LABEL_CLASSES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  wds_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output wds_pkg::t_out o_out_data
);
    // ring slot index width; a one-deep ring still keeps one bit
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    wds_pkg::t_cmd     cmd;
    wds_pkg::t_stat    stat;
    logic [SLOT_W-1:0] row, len_last;

    // sequencer: decides what the datapath does each cycle
    wds_ctrl #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .VIEW_CLASSES  (VIEW_CLASSES),
        .LABEL_CLASSES (LABEL_CLASSES),
        .SLOT_W        (SLOT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .i_len_last (len_last),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .o_row      (row)
    );

    // datapath: staging, ring memories, sums, divider, output register
    wds_dp #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .VIEW_CLASSES  (VIEW_CLASSES),
        .LABEL_CLASSES (LABEL_CLASSES),
        .SLOT_W        (SLOT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_row       (row),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_len_last  (len_last),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // load the output register only when the previous beat is gone or leaving
    `WDS_ASSERT_IMP(a_load_free, cmd.push_det || cmd.push_fin || cmd.err_out, stat.out_free)
    // the closing push of a frame shows up as a last beat
    `WDS_ASSERT_NXT(a_fin_last, cmd.push_fin, o_out_valid && o_out_data.last_result)
    // an error result is always the only beat of its frame
    `WDS_ASSERT_IMP(a_err_last, o_out_valid && o_out_data.out_kind == wds_pkg::KIND_ERR,
                    o_out_data.last_result)
endmodule

### tb/sv/tb_wds_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the windowed detection smoother: mirrors the frame ring,
// predicts the results of each end-of-frame beat and checks the output beats.
// Depends on wds_pkg for the payload types and the operation, kind and register codes.
module tb_wds_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  wds_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  wds_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);
    import wds_pkg::*;

    localparam int DEPTH  = 16;
    localparam int VIEWS  = 8;
    localparam int LABELS = 8;

    logic [4:0]  win_len;
    logic [15:0] thr_level;
    logic [15:0] label_frac;
    logic [63:0] label_mask;

    logic [15:0] ring_view [DEPTH][VIEWS];
    logic [63:0] ring_box  [DEPTH][LABELS];
    logic [15:0] ring_conf [DEPTH][LABELS];
    int unsigned next_slot;
    logic [15:0] frame_view [VIEWS];
    logic [63:0] frame_box  [LABELS];
    logic [15:0] frame_conf [LABELS];
    int unsigned views_seen;

    t_out smoothed_q[$];
    int   fails;

    assign o_fail_count = fails;
    assign o_pending    = smoothed_q.size();

    task automatic drop_frame();
        for (int l = 0; l < LABELS; l++) begin
            frame_box[l]  = '0;
            frame_conf[l] = '0;
        end
        views_seen = 0;
    endtask

    task automatic clear_ring();
        for (int f = 0; f < DEPTH; f++) begin
            for (int v = 0; v < VIEWS; v++) ring_view[f][v] = '0;
            for (int l = 0; l < LABELS; l++) begin
                ring_box[f][l]  = '0;
                ring_conf[f][l] = '0;
            end
        end
        next_slot = 0;
    endtask

    // Close a frame: unless its view count is wrong, store it in the ring; queue every result it causes.
    task automatic close_frame();
        int unsigned len, slot, best, best_mean, mean, sum, need, cnt;
        int unsigned acc [5];
        t_out r;
        bit keep;
        len  = (win_len == 0) ? 1 : ((win_len > DEPTH) ? DEPTH : win_len);
        slot = (next_slot < len) ? next_slot : 0;
        next_slot = (slot + 1 >= len) ? 0 : slot + 1;
        r = '0;
        if (views_seen != VIEWS) begin
            drop_frame();
            r.out_kind    = KIND_ERR;
            r.last_result = 1'b1;
            smoothed_q.insert(smoothed_q.size(), r);
            return;
        end
        for (int v = 0; v < VIEWS; v++) ring_view[slot][v] = frame_view[v];
        best = 0;
        best_mean = 0;
        for (int v = 0; v < VIEWS; v++) begin
            sum = 0;
            for (int f = 0; f < len; f++) sum += ring_view[f][v];
            mean = sum / len;
            if (v == 0 || mean > best_mean) begin
                best_mean = mean;
                best = v;
            end
        end
        keep = best_mean > thr_level;
        for (int l = 0; l < LABELS; l++) begin
            ring_box[slot][l]  = keep ? frame_box[l] : '0;
            ring_conf[slot][l] = keep ? frame_conf[l] : '0;
        end
        drop_frame();
        need = (len * label_frac) >> 16;
        r.out_kind   = KIND_VIEW;
        r.view_class = best[2:0];
        r.view_prob  = best_mean[15:0];
        smoothed_q.insert(smoothed_q.size(), r);
        for (int l = 0; l < LABELS; l++) begin
            if (!label_mask[best * 8 + l]) continue;
            cnt = 0;
            for (int i = 0; i < 5; i++) acc[i] = 0;
            for (int f = 0; f < len; f++) begin
                if (ring_conf[f][l] == 0) continue;
                cnt++;
                acc[0] += ring_box[f][l][15:0];
                acc[1] += ring_box[f][l][31:16];
                acc[2] += ring_box[f][l][47:32];
                acc[3] += ring_box[f][l][63:48];
                acc[4] += ring_conf[f][l];
            end
            if (cnt > need) begin
                r.out_kind  = KIND_DET;
                r.out_label = l[2:0];
                r.avg_x     = 16'(acc[0] / cnt);
                r.avg_y     = 16'(acc[1] / cnt);
                r.avg_w     = 16'(acc[2] / cnt);
                r.avg_h     = 16'(acc[3] / cnt);
                r.avg_conf  = 16'(acc[4] / cnt);
                smoothed_q.insert(smoothed_q.size(), r);
            end
        end
        r = smoothed_q[smoothed_q.size() - 1];
        r.last_result = 1'b1;
        smoothed_q[smoothed_q.size() - 1] = r;
    endtask

    task automatic take_item(input t_in it);
        case (it.operation)
            OP_VIEW: begin
                frame_view[it.in_index] = it.in_score;
                if (views_seen < 15) views_seen++;
            end
            OP_DET: begin
                frame_box[it.in_index]  = {it.in_h, it.in_w, it.in_y, it.in_x};
                frame_conf[it.in_index] = it.in_conf;
            end
            OP_CLR: begin
                clear_ring();
                drop_frame();
            end
            default: close_frame();
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_beat(input t_out got);
        t_out want;
        if (smoothed_q.size() == 0) begin
            fails++;
            $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
            return;
        end
        want = smoothed_q.pop_front();
        check_field("out_kind",    want.out_kind,    got.out_kind);
        check_field("view_class",  want.view_class,  got.view_class);
        check_field("view_prob",   want.view_prob,   got.view_prob);
        check_field("out_label",   want.out_label,   got.out_label);
        check_field("avg_x",       want.avg_x,       got.avg_x);
        check_field("avg_y",       want.avg_y,       got.avg_y);
        check_field("avg_w",       want.avg_w,       got.avg_w);
        check_field("avg_h",       want.avg_h,       got.avg_h);
        check_field("avg_conf",    want.avg_conf,    got.avg_conf);
        check_field("last_result", want.last_result, got.last_result);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_len     = RST_WINDOW;
            thr_level   = RST_THRESH;
            label_frac  = RST_FRAC;
            label_mask  = '1;
            clear_ring();
            for (int v = 0; v < VIEWS; v++) frame_view[v] = '0;
            drop_frame();
            smoothed_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW: win_len     = i_cfg_data[4:0];
                    CFG_THRESH: thr_level   = i_cfg_data[15:0];
                    CFG_FRAC:   label_frac  = i_cfg_data[15:0];
                    default:    label_mask  = i_cfg_data;
                endcase
            end
            if (i_out_valid && i_out_ready) check_beat(i_out_data);
            if (i_in_valid && i_in_ready) take_item(i_in_data);
        end
    end

endmodule

### tb/sv/tb_windowed_detection_smoother.sv
`timescale 1ns / 1ps
// Top of the windowed detection smoother testbench: clock, reset, stimulus and verdict.
// Depends on wds_pkg, the block itself and the tb_wds_checker scoreboard.
module tb_windowed_detection_smoother;
    import wds_pkg::*;

    // The watchdog limit lies far above the worst frame close.
    localparam int STALL_LIMIT = 40000;
    localparam int ITEMS_PER_SEG = 68;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int quiet_cycles;

    windowed_detection_smoother u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    tb_wds_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: drop ready at random for the current share of cycles.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any accepted beat on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one beat, idling first at random, and hold it until accepted.
    // Valid stays high across back-to-back beats.
    task automatic send_beat(input t_in it);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_view(input logic [2:0] idx, input logic [15:0] score);
        t_in it;
        it = t_in'({$urandom, $urandom, $urandom, $urandom});
        it.operation = OP_VIEW;
        it.in_index  = idx;
        it.in_score  = score;
        send_beat(it);
    endtask

    task automatic send_box(input logic [2:0] lab, input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [15:0] conf);
        t_in it;
        it = t_in'({$urandom, $urandom, $urandom, $urandom});
        it.operation = OP_DET;
        it.in_index  = lab;
        it.in_x = x;
        it.in_y = y;
        it.in_w = w;
        it.in_h = h;
        it.in_conf = conf;
        send_beat(it);
    endtask

    task automatic send_op(input logic [1:0] op);
        t_in it;
        it = t_in'({$urandom, $urandom, $urandom, $urandom});
        it.operation = op;
        send_beat(it);
    endtask

    // One frame: a full set of view scores in shuffled order, or a wrong count
    // when broken, then some boxes and the end-of-frame beat.
    task automatic send_frame(input bit broken);
        int order [8];
        int n_views, n_boxes, j, tmp;
        bit low_scores;
        for (int i = 0; i < 8; i++) order[i] = i;
        for (int i = 7; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        low_scores = ($urandom_range(3) == 0);
        n_views = 8;
        if (broken) begin
            n_views = $urandom_range(12);
            if (n_views == 8) n_views = 9;
        end
        for (int i = 0; i < n_views; i++) begin
            send_view(broken ? 3'($urandom) : 3'(order[i]),
                      low_scores ? 16'($urandom_range(20000)) : 16'($urandom));
        end
        n_boxes = $urandom_range(10);
        for (int i = 0; i < n_boxes; i++) begin
            send_box(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom),
                     ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom));
        end
        send_op(OP_EOF);
    endtask

    // Stop sending and wait for the block to drain before touching registers.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(input int seg);
        logic [4:0]  win;
        logic [15:0] thr, frac;
        logic [63:0] mask;
        case (seg)
            0: begin win = 5'd16; thr = 16'd0;     frac = 16'd0;     mask = '1; end
            1: begin
                win  = 5'd1;
                thr  = 16'hFFFF;
                frac = 16'hFFFF;
                mask = {$urandom, $urandom};
            end
            2: begin
                win  = 5'($urandom_range(1, 16));
                thr  = 16'($urandom_range(30000));
                frac = 16'($urandom);
                mask = {$urandom, $urandom};
            end
            3: begin win = 5'd3;  thr = RST_THRESH; frac = 16'd30000; mask = '1; end
            4: begin win = 5'd16; thr = 16'd100;    frac = 16'hFFFF;  mask = 64'd0; end
            default: begin
                win  = 5'($urandom_range(1, 8));
                thr  = 16'($urandom_range(30000));
                frac = 16'($urandom_range(40000));
                mask = {$urandom, $urandom};
            end
        endcase
        write_reg(CFG_WINDOW, 64'(win));
        write_reg(CFG_THRESH, 64'(thr));
        write_reg(CFG_FRAC, 64'(frac));
        write_reg(CFG_MASK, mask);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int target, pick;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;
        quiet_cycles  = 0;
        items_sent    = 0;
        send_idle_pct = 22;
        recv_idle_pct = 56;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first frame writes every view score so none is read unwritten.
        send_view(3'd0, 16'hFFFF);
        send_view(3'd1, 16'd0);
        for (int v = 2; v < 8; v++) send_view(3'(v), 16'h8000);
        send_view(3'd0, 16'hFFFF);                // overwrite counts again: now nine views
        send_box(3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
        send_op(OP_EOF);                          // view count error
        for (int v = 0; v < 8; v++) send_view(3'(v), (v == 0) ? 16'hFFFF : 16'd0);
        send_box(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_box(3'd3, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5);
        send_box(3'd3, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd1);  // later box wins
        send_box(3'd5, 16'd9, 16'd9, 16'd9, 16'd9, 16'd0);        // absent label
        send_op(OP_EOF);
        send_op(OP_EOF);                          // no views at all
        send_op(OP_CLR);
        drain();

        for (int seg = 0; seg < 6; seg++) begin
            send_idle_pct = (seg < 2) ? 22 : ((seg < 4) ? 56 : 0);
            recv_idle_pct = (seg < 2) ? 56 : ((seg < 4) ? 22 : 0);
            configure(seg);
            target = items_sent + ITEMS_PER_SEG;
            while (items_sent < target) begin
                pick = $urandom_range(99);
                if (pick < 75)      send_frame(1'b0);
                else if (pick < 88) send_frame(1'b1);
                else if (pick < 97) send_beat(t_in'({$urandom, $urandom, $urandom, $urandom}));
                else                send_op(OP_CLR);
            end
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### windowed_detection_smoother.f
+incdir+rtl/core
rtl/core/wds_pkg.sv
rtl/core/wds_div.sv
rtl/core/wds_ctrl.sv
rtl/core/wds_dp.sv
rtl/core/windowed_detection_smoother.sv
tb/sv/tb_wds_checker.sv
tb/sv/tb_windowed_detection_smoother.sv
